// File: rtl/hkm_pkg.sv
`timescale 1ns / 1ps

package hkm_pkg;

    localparam int MATRIX_ROWS = 8;
    localparam int NUM_COLS    = 5;
    localparam int KEY_W       = 8;

    localparam logic [2:0] MAX_COL   = 3'd4;
    localparam logic [7:0] NO_KEY    = 8'd0;
    localparam logic [3:0] NO_ROW    = 4'd8;
    localparam logic [7:0] READ_NONE = 8'hFF;

    typedef enum logic [2:0] {
        CMD_PRESS   = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_ROW     = 3'd2,
        CMD_READ    = 3'd3,
        CMD_ADD     = 3'd4,
        CMD_CLEAR   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REPLACED = 2'd1,
        ST_FULL     = 2'd2,
        ST_REJECT   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_LSHIFT = 2'd0,
        CFG_RSHIFT = 2'd1,
        CFG_ALTGR  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             shift;
        logic             altgr;
        logic [2:0]       row;
        logic [2:0]       col;
        logic             tshift;
    } map_entry_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
        logic             shift;
        logic             altgr;
    } map_req_t;

    typedef struct packed {
        logic       en;
        logic       clear;
        map_entry_t entry;
    } map_wr_t;

    typedef struct packed {
        logic       done;
        logic       found;
        logic       free_found;
        map_entry_t entry;
    } map_rsp_t;

    typedef struct packed {
        logic             push;
        logic             remove;
        logic [KEY_W-1:0] key;
        logic             shift;
    } held_cmd_t;

endpackage

// File: rtl/hkm_if.sv
`timescale 1ns / 1ps

interface hkm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] host_key;
    logic       host_shift;
    logic       host_altgr;
    logic [2:0] target_row;
    logic [2:0] target_col;
    logic       target_shift;
    logic [7:0] row_select;

    modport source (
        output valid, command, host_key, host_shift, host_altgr,
               target_row, target_col, target_shift, row_select,
        input  ready
    );
    modport sink (
        input  valid, command, host_key, host_shift, host_altgr,
               target_row, target_col, target_shift, row_select,
        output ready
    );
endinterface

interface hkm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] status;

    modport source (output valid, read_data, status, input ready);
    modport sink (input valid, read_data, status, output ready);
endinterface

interface hkm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/hkm_map.sv
`timescale 1ns / 1ps

module hkm_map
    import hkm_pkg::*;
#(
    parameter int MAP_DEPTH = 128,
    localparam int IDX_W    = $clog2(MAP_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  map_req_t         req,
    input  map_wr_t          wr,
    input  logic [IDX_W-1:0] wr_idx,
    output map_rsp_t         rsp,
    output logic [IDX_W-1:0] match_idx,
    output logic [IDX_W-1:0] free_idx
);

    map_entry_t         mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] valid_reg;

    logic               busy_reg;
    logic [IDX_W:0]     issue_reg;
    logic               pipe_vld_reg;
    map_entry_t         rd_entry_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_idx_reg;

    logic [KEY_W-1:0]   key_reg;
    logic               shift_reg;
    logic               altgr_reg;

    logic               done_reg;
    logic               found_reg;
    logic               free_found_reg;
    map_entry_t         match_entry_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic               cmp_en;
    logic               hit;
    logic               last;
    logic               issuing;

    // one compare per cycle against the registered read beat
    assign cmp_en  = busy_reg && pipe_vld_reg;
    assign hit     = cmp_en && rd_valid_reg && rd_entry_reg.key == key_reg
                     && rd_entry_reg.shift == shift_reg
                     && rd_entry_reg.altgr == altgr_reg;
    assign last    = cmp_en && rd_idx_reg == IDX_W'(MAP_DEPTH - 1);
    assign issuing = busy_reg && !hit && !last
                     && issue_reg < (IDX_W + 1)'(MAP_DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_idx] <= wr.entry;
        end
        if (issuing)
        begin
            rd_entry_reg <= mem[issue_reg[IDX_W-1:0]];
            rd_valid_reg <= valid_reg[issue_reg[IDX_W-1:0]];
            rd_idx_reg   <= issue_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            busy_reg       <= 1'b0;
            issue_reg      <= '0;
            pipe_vld_reg   <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (wr.clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end

            if (req.start)
            begin
                busy_reg       <= 1'b1;
                issue_reg      <= '0;
                pipe_vld_reg   <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                key_reg        <= req.key;
                shift_reg      <= req.shift;
                altgr_reg      <= req.altgr;
            end
            else
            begin
                pipe_vld_reg <= issuing;
                if (issuing)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
                if (cmp_en)
                begin
                    if (hit)
                    begin
                        found_reg       <= 1'b1;
                        match_idx_reg   <= rd_idx_reg;
                        match_entry_reg <= rd_entry_reg;
                    end
                    if (!rd_valid_reg && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= rd_idx_reg;
                    end
                    if (hit || last)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign rsp.done       = done_reg;
    assign rsp.found      = found_reg;
    assign rsp.free_found = free_found_reg;
    assign rsp.entry      = match_entry_reg;
    assign match_idx      = match_idx_reg;
    assign free_idx       = free_idx_reg;

endmodule

// File: rtl/hkm_held.sv
`timescale 1ns / 1ps

module hkm_held
    import hkm_pkg::*;
#(
    parameter int HELD_DEPTH = 8,
    localparam int HW        = $clog2(HELD_DEPTH),
    localparam int CW        = $clog2(HELD_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  held_cmd_t        cmd,
    input  logic [HW-1:0]    rm_idx,
    input  logic [KEY_W-1:0] find_key,
    output logic             find_hit,
    output logic [HW-1:0]    find_idx,
    output logic             find_shift,
    output logic             full
);

    logic [KEY_W-1:0] key_reg   [HELD_DEPTH];
    logic             shift_reg [HELD_DEPTH];
    logic [CW-1:0]    count_reg;

    always_comb
    begin
        find_hit = 1'b0;
        find_idx = '0;
        for (int i = HELD_DEPTH - 1; i >= 0; i--)
        begin
            if (CW'(i) < count_reg && key_reg[i] == find_key)
            begin
                find_hit = 1'b1;
                find_idx = HW'(i);
            end
        end
    end

    assign find_shift = shift_reg[find_idx];
    assign full       = count_reg == CW'(HELD_DEPTH);

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            key_reg[count_reg[HW-1:0]]   <= cmd.key;
            shift_reg[count_reg[HW-1:0]] <= cmd.shift;
        end
        else if (cmd.remove)
        begin
            for (int j = 0; j < HELD_DEPTH - 1; j++)
            begin
                if (HW'(j) >= rm_idx)
                begin
                    key_reg[j]   <= key_reg[j+1];
                    shift_reg[j] <= shift_reg[j+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.push)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (cmd.remove)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/host_key_to_scan_matrix.sv
// Path: row write, read, clear map and key events with no map lookup go from accept
// through dispatch and finish to the output register; other press, release and add map beats
// also walk the map in search, one entry a cycle. Flow: one beat at a time; the next beat is
// taken once back in idle, later while the previous result waits in the output register.
// Reset: matrix cleared, no row selected, held list and map empty; map memory data is
// not cleared, only its per-entry valid flops.
`timescale 1ns / 1ps

module host_key_to_scan_matrix
    import hkm_pkg::*;
#(
    parameter int MAP_DEPTH  = 128,
    parameter int HELD_DEPTH = 8
)
(
    input logic       clk,
    input logic       rst_n,
    hkm_in_if.sink    key_in,
    hkm_out_if.source res_out,
    hkm_cfg_if.sink   cfg
);

    localparam int MIW = $clog2(MAP_DEPTH);
    localparam int HIW = $clog2(HELD_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_FINISH
    } state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic             hsh_reg;
    logic             hag_reg;
    logic [2:0]       trow_reg;
    logic [2:0]       tcol_reg;
    logic             tsh_reg;
    logic [7:0]       rsel_reg;

    logic [KEY_W-1:0] lshift_reg;
    logic [KEY_W-1:0] rshift_reg;
    logic [KEY_W-1:0] altgr_reg;

    logic [NUM_COLS-1:0] matrix_reg [MATRIX_ROWS];
    logic [3:0]          scan_row_reg;
    logic                shift_held_reg;
    logic [HIW-1:0]      held_idx_reg;

    logic [7:0] res_data_reg;
    status_t    res_status_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    status_t    out_status_reg;

    logic [7:0] disp_data;
    status_t    disp_status;

    map_req_t       map_req;
    map_wr_t        map_wr;
    map_rsp_t       map_rsp;
    logic [MIW-1:0] map_wr_idx;
    logic [MIW-1:0] match_idx;
    logic [MIW-1:0] free_idx;

    held_cmd_t      held_cmd;
    logic           held_hit;
    logic [HIW-1:0] held_idx;
    logic           held_shift;
    logic           held_full;

    logic                is_shift;
    logic [NUM_COLS-1:0] mat_press [MATRIX_ROWS];
    logic [NUM_COLS-1:0] mat_rel   [MATRIX_ROWS];

    function automatic logic [3:0] first_zero(input logic [7:0] sel);
        logic [3:0] r;
        r = NO_ROW;
        for (int b = 7; b >= 0; b--)
        begin
            if (!sel[b])
            begin
                r = 4'(b);
            end
        end
        return r;
    endfunction

    function automatic logic [NUM_COLS-1:0] col_mask(input logic [2:0] col);
        logic [NUM_COLS-1:0] m;
        m = '0;
        for (int c = 0; c < NUM_COLS; c++)
        begin
            if (col == 3'(c))
            begin
                m[c] = 1'b1;
            end
        end
        return m;
    endfunction

    assign is_shift = key_reg == lshift_reg || key_reg == rshift_reg;

    always_comb
    begin
        map_req.start = 1'b0;
        if (state_reg == S_DISPATCH && key_reg != NO_KEY && !is_shift)
        begin
            case (cmd_reg)
                CMD_PRESS:   map_req.start = !held_full;
                CMD_RELEASE: map_req.start = key_reg != altgr_reg && held_hit;
                default:     map_req.start = 1'b0;
            endcase
        end
        if (state_reg == S_DISPATCH && cmd_reg == CMD_ADD && key_reg != NO_KEY
            && tcol_reg <= MAX_COL)
        begin
            map_req.start = 1'b1;
        end
        map_req.key = key_reg;
        case (cmd_reg)
            CMD_PRESS:   map_req.shift = shift_held_reg;
            CMD_RELEASE: map_req.shift = held_shift;
            default:     map_req.shift = hsh_reg;
        endcase
        map_req.altgr = cmd_reg == CMD_ADD ? hag_reg : 1'b0;
    end

    always_comb
    begin
        map_wr.en = state_reg == S_SEARCH && map_rsp.done && cmd_reg == CMD_ADD
                    && (map_rsp.found || map_rsp.free_found);
        map_wr.clear        = state_reg == S_DISPATCH && cmd_reg == CMD_CLEAR;
        map_wr.entry.key    = key_reg;
        map_wr.entry.shift  = hsh_reg;
        map_wr.entry.altgr  = hag_reg;
        map_wr.entry.row    = trow_reg;
        map_wr.entry.col    = tcol_reg;
        map_wr.entry.tshift = tsh_reg;
        map_wr_idx = map_rsp.found ? match_idx : free_idx;
    end

    always_comb
    begin
        held_cmd.push = state_reg == S_SEARCH && map_rsp.done && cmd_reg == CMD_PRESS
                        && map_rsp.found;
        held_cmd.remove = state_reg == S_SEARCH && map_rsp.done
                          && cmd_reg == CMD_RELEASE && map_rsp.found;
        held_cmd.key   = key_reg;
        held_cmd.shift = shift_held_reg;
    end

    // result of commands settled without a map walk
    always_comb
    begin
        disp_data   = '0;
        disp_status = ST_OK;
        case (cmd_reg)
            CMD_PRESS:
            begin
                if (key_reg == NO_KEY || (!is_shift && held_full))
                begin
                    disp_status = ST_REJECT;
                end
            end
            CMD_RELEASE:
            begin
                if (key_reg == NO_KEY
                    || (!is_shift && key_reg != altgr_reg && !held_hit))
                begin
                    disp_status = ST_REJECT;
                end
            end
            CMD_READ:
            begin
                if (scan_row_reg[3])
                begin
                    disp_data = READ_NONE;
                end
                else
                begin
                    disp_data = {3'b111, ~matrix_reg[scan_row_reg[2:0]]};
                end
            end
            CMD_ADD:
            begin
                if (key_reg == NO_KEY || tcol_reg > MAX_COL)
                begin
                    disp_status = ST_REJECT;
                end
            end
            default:
            begin
            end
        endcase
    end

    // press: shift key follows entry flag, then mapped key set
    // release: mapped key lifted, then shift key follows host shift
    always_comb
    begin
        mat_press = matrix_reg;
        mat_press[0][0] = map_rsp.entry.tshift;
        mat_press[map_rsp.entry.row] = mat_press[map_rsp.entry.row]
                                       | col_mask(map_rsp.entry.col);
        mat_rel = matrix_reg;
        mat_rel[map_rsp.entry.row] = mat_rel[map_rsp.entry.row]
                                     & ~col_mask(map_rsp.entry.col);
        mat_rel[0][0] = shift_held_reg;
    end

    hkm_map #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (map_req),
        .wr        (map_wr),
        .wr_idx    (map_wr_idx),
        .rsp       (map_rsp),
        .match_idx (match_idx),
        .free_idx  (free_idx)
    );

    hkm_held #(
        .HELD_DEPTH (HELD_DEPTH)
    ) u_held (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (held_cmd),
        .rm_idx     (held_idx_reg),
        .find_key   (key_reg),
        .find_hit   (held_hit),
        .find_idx   (held_idx),
        .find_shift (held_shift),
        .full       (held_full)
    );

    assign key_in.ready      = state_reg == S_IDLE;
    assign cfg.ready         = 1'b1;
    assign res_out.valid     = out_valid_reg;
    assign res_out.read_data = out_data_reg;
    assign res_out.status    = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lshift_reg <= '0;
            rshift_reg <= '0;
            altgr_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_LSHIFT: lshift_reg <= cfg.data;
                CFG_RSHIFT: rshift_reg <= cfg.data;
                CFG_ALTGR:  altgr_reg  <= cfg.data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_row_reg   <= NO_ROW;
            shift_held_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int r = 0; r < MATRIX_ROWS; r++)
            begin
                matrix_reg[r] <= '0;
            end
        end
        else
        begin
            if (state_reg == S_FINISH && (!out_valid_reg || res_out.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (key_in.valid)
                    begin
                        cmd_reg   <= cmd_t'(key_in.command);
                        key_reg   <= key_in.host_key;
                        hsh_reg   <= key_in.host_shift;
                        hag_reg   <= key_in.host_altgr;
                        trow_reg  <= key_in.target_row;
                        tcol_reg  <= key_in.target_col;
                        tsh_reg   <= key_in.target_shift;
                        rsel_reg  <= key_in.row_select;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    res_data_reg   <= disp_data;
                    res_status_reg <= disp_status;
                    held_idx_reg   <= held_idx;
                    state_reg      <= map_req.start ? S_SEARCH : S_FINISH;
                    case (cmd_reg)
                        CMD_PRESS:
                        begin
                            if (key_reg != NO_KEY && is_shift)
                            begin
                                shift_held_reg   <= 1'b1;
                                matrix_reg[0][0] <= 1'b1;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            if (key_reg != NO_KEY && is_shift)
                            begin
                                shift_held_reg   <= 1'b0;
                                matrix_reg[0][0] <= 1'b0;
                            end
                        end
                        CMD_ROW:
                        begin
                            scan_row_reg <= first_zero(rsel_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SEARCH:
                begin
                    if (map_rsp.done)
                    begin
                        state_reg <= S_FINISH;
                        case (cmd_reg)
                            CMD_PRESS:
                            begin
                                if (map_rsp.found)
                                begin
                                    matrix_reg <= mat_press;
                                end
                                else
                                begin
                                    res_status_reg <= ST_REJECT;
                                end
                            end
                            CMD_RELEASE:
                            begin
                                if (map_rsp.found)
                                begin
                                    matrix_reg <= mat_rel;
                                end
                                else
                                begin
                                    res_status_reg <= ST_REJECT;
                                end
                            end
                            CMD_ADD:
                            begin
                                if (map_rsp.found)
                                begin
                                    res_status_reg <= ST_REPLACED;
                                end
                                else if (!map_rsp.free_found)
                                begin
                                    res_status_reg <= ST_FULL;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || res_out.ready)
                    begin
                        out_data_reg   <= res_data_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/sv/hkm_checker.sv
`timescale 1ns / 1ps

module hkm_checker
    import hkm_pkg::*;
#(
    parameter int MAP_DEPTH  = 128,
    parameter int HELD_DEPTH = 8
)
(
    input  logic clk,
    input  logic rst_n,
    hkm_in_if    key_in,
    hkm_out_if   res_out,
    hkm_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic [7:0] read_data;
        status_t    status;
    } scan_result_t;

    typedef struct packed {
        logic [7:0] key;
        logic       shift;
    } held_key_t;

    logic [NUM_COLS-1:0] matrix [MATRIX_ROWS];
    logic [3:0]          scan_row;
    logic                shift_down;
    held_key_t           held [HELD_DEPTH];
    int                  held_cnt;
    map_entry_t          map_tbl [MAP_DEPTH];
    logic                map_vld [MAP_DEPTH];
    logic [7:0]          lshift_code;
    logic [7:0]          rshift_code;
    logic [7:0]          altgr_code;
    scan_result_t        due_results [$];
    int                  result_no;

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < MAX_REPORTS)
            $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                     result_no, what, got, want);
        fail_count++;
    endtask

    function automatic int map_lookup(logic [7:0] k, logic s, logic a);
        for (int i = 0; i < MAP_DEPTH; i++)
            if (map_vld[i] && map_tbl[i].key == k && map_tbl[i].shift == s &&
                map_tbl[i].altgr == a)
                return i;
        return -1;
    endfunction

    function automatic status_t key_down(logic [7:0] k);
        int m;
        if (k == NO_KEY)
            return ST_REJECT;
        if (k == lshift_code || k == rshift_code)
        begin
            shift_down   = 1'b1;
            matrix[0][0] = 1'b1;
            return ST_OK;
        end
        m = map_lookup(k, shift_down, 1'b0);
        if (m < 0 || held_cnt >= HELD_DEPTH)
            return ST_REJECT;
        matrix[0][0] = map_tbl[m].tshift;
        matrix[map_tbl[m].row][map_tbl[m].col] = 1'b1;
        held[held_cnt] = '{key: k, shift: shift_down};
        held_cnt++;
        return ST_OK;
    endfunction

    function automatic status_t key_up(logic [7:0] k);
        int slot;
        int m;
        if (k == NO_KEY)
            return ST_REJECT;
        if (k == lshift_code || k == rshift_code)
        begin
            shift_down   = 1'b0;
            matrix[0][0] = 1'b0;
            return ST_OK;
        end
        if (k == altgr_code)
            return ST_OK;
        slot = -1;
        for (int i = held_cnt - 1; i >= 0; i--)
            if (held[i].key == k)
                slot = i;
        if (slot < 0)
            return ST_REJECT;
        m = map_lookup(held[slot].key, held[slot].shift, 1'b0);
        if (m < 0)
            return ST_REJECT;
        matrix[map_tbl[m].row][map_tbl[m].col] = 1'b0;
        matrix[0][0] = shift_down;
        for (int j = slot; j < held_cnt - 1; j++)
            held[j] = held[j + 1];
        held_cnt--;
        return ST_OK;
    endfunction

    function automatic status_t map_add();
        int m;
        if (key_in.host_key == NO_KEY || key_in.target_col > MAX_COL)
            return ST_REJECT;
        m = map_lookup(key_in.host_key, key_in.host_shift, key_in.host_altgr);
        if (m >= 0)
        begin
            map_tbl[m].row    = key_in.target_row;
            map_tbl[m].col    = key_in.target_col;
            map_tbl[m].tshift = key_in.target_shift;
            return ST_REPLACED;
        end
        for (int i = 0; i < MAP_DEPTH; i++)
            if (!map_vld[i])
            begin
                map_tbl[i] = '{key: key_in.host_key, shift: key_in.host_shift,
                               altgr: key_in.host_altgr, row: key_in.target_row,
                               col: key_in.target_col, tshift: key_in.target_shift};
                map_vld[i] = 1'b1;
                return ST_OK;
            end
        return ST_FULL;
    endfunction

    function automatic scan_result_t apply_key_beat();
        scan_result_t r;
        r.read_data = '0;
        r.status    = ST_OK;
        case (key_in.command)
            CMD_PRESS:   r.status = key_down(key_in.host_key);
            CMD_RELEASE: r.status = key_up(key_in.host_key);
            CMD_ROW:
            begin
                scan_row = NO_ROW;
                for (int b = MATRIX_ROWS - 1; b >= 0; b--)
                    if (!key_in.row_select[b])
                        scan_row = 4'(b);
            end
            CMD_READ:
            begin
                if (scan_row >= NO_ROW)
                    r.read_data = READ_NONE;
                else
                    r.read_data = {3'b111, ~matrix[scan_row[2:0]]};
            end
            CMD_ADD:     r.status = map_add();
            CMD_CLEAR:
            begin
                foreach (map_vld[i])
                    map_vld[i] = 1'b0;
            end
            default:     ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t want;
        if (!rst_n)
        begin
            foreach (matrix[i])
                matrix[i] = '0;
            foreach (map_vld[i])
                map_vld[i] = 1'b0;
            scan_row    = NO_ROW;
            shift_down  = 1'b0;
            held_cnt    = 0;
            lshift_code = '0;
            rshift_code = '0;
            altgr_code  = '0;
            due_results.delete();
            result_no   = 0;
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (res_out.valid && res_out.ready)
            begin
                if (due_results.size() == 0)
                    report_mismatch("unexpected beat, read_data", res_out.read_data, 0);
                else
                begin
                    want = due_results.pop_front();
                    if (res_out.read_data !== want.read_data)
                        report_mismatch("read_data", res_out.read_data, want.read_data);
                    if (res_out.status !== want.status)
                        report_mismatch("status", res_out.status, want.status);
                end
                result_no++;
            end
            if (key_in.valid && key_in.ready)
                due_results.insert(due_results.size(), apply_key_beat());
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_LSHIFT: lshift_code = cfg.data;
                    CFG_RSHIFT: rshift_code = cfg.data;
                    CFG_ALTGR:  altgr_code  = cfg.data;
                    default:    ;
                endcase
            end
            pending = due_results.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import hkm_pkg::*;

    localparam int MAP_DEPTH       = 128;
    localparam int HELD_DEPTH      = 8;
    localparam int ITEMS_PER_PHASE = 560;
    localparam int POOL_SIZE       = 12;
    localparam int MAX_DOWN        = 12;
    localparam int HOLD_OFF_LEN    = 300;
    localparam int DRAIN_CYCLES    = MAP_DEPTH + 16;

    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] host_key;
        logic       host_shift;
        logic       host_altgr;
        logic [2:0] target_row;
        logic [2:0] target_col;
        logic       target_shift;
        logic [7:0] row_select;
    } key_beat_t;

    localparam int BEAT_W = $bits(key_beat_t);

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_results;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_off_cycles = 0;
    bit   hold_off_done   = 1'b0;

    logic [7:0] codes [3];
    logic [7:0] key_pool [POOL_SIZE];
    logic [7:0] down_keys [$];

    hkm_in_if  key_in();
    hkm_out_if res_out();
    hkm_cfg_if cfg();

    host_key_to_scan_matrix #(
        .MAP_DEPTH  (MAP_DEPTH),
        .HELD_DEPTH (HELD_DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_in  (key_in),
        .res_out (res_out),
        .cfg     (cfg)
    );

    hkm_checker #(
        .MAP_DEPTH  (MAP_DEPTH),
        .HELD_DEPTH (HELD_DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_in     (key_in),
        .res_out    (res_out),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending_results)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic key_beat_t scrambled(logic [2:0] c, logic [7:0] k);
        key_beat_t b;
        b          = key_beat_t'(BEAT_W'($urandom));
        b.command  = c;
        b.host_key = k;
        return b;
    endfunction

    function automatic key_beat_t map_beat(logic [7:0] k, logic s, logic a,
                                           logic [2:0] r, logic [2:0] c, logic t);
        key_beat_t b;
        b              = scrambled(CMD_ADD, k);
        b.host_shift   = s;
        b.host_altgr   = a;
        b.target_row   = r;
        b.target_col   = c;
        b.target_shift = t;
        return b;
    endfunction

    function automatic key_beat_t row_beat(logic [7:0] sel);
        key_beat_t b;
        b            = scrambled(CMD_ROW, 8'($urandom));
        b.row_select = sel;
        return b;
    endfunction

    // called on a falling edge; returns on the falling edge after the beat is taken
    task automatic send_beat(key_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            key_in.valid <= 1'b0;
            @(negedge clk);
        end
        key_in.valid        <= 1'b1;
        key_in.command      <= b.command;
        key_in.host_key     <= b.host_key;
        key_in.host_shift   <= b.host_shift;
        key_in.host_altgr   <= b.host_altgr;
        key_in.target_row   <= b.target_row;
        key_in.target_col   <= b.target_col;
        key_in.target_shift <= b.target_shift;
        key_in.row_select   <= b.row_select;
        @(posedge clk);
        while (!key_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        key_in.valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    task automatic load_codes(logic [7:0] lsh, logic [7:0] rsh, logic [7:0] agr);
        cfg_idx_t idx [3];
        idx   = '{CFG_LSHIFT, CFG_RSHIFT, CFG_ALTGR};
        codes = '{lsh, rsh, agr};
        for (int i = 0; i < 3; i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= idx[i];
            cfg.data  <= codes[i];
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic run_traffic(int n);
        key_beat_t  b;
        logic [7:0] k;
        logic [7:0] sel;
        int         pick;
        int         sub;
        int         slot;
        foreach (key_pool[i])
            key_pool[i] = (i < POOL_SIZE / 2) ? 8'($urandom_range(40, 1))
                                              : 8'($urandom_range(255, 1));
        for (int i = 0; i < n; i++)
        begin
            // halfway through, push the map past full with distinct keys
            if (i == n / 2)
                for (int f = 1; f <= MAP_DEPTH + 2; f++)
                    send_beat(map_beat(8'(f), 1'($urandom), 1'($urandom_range(3) == 0),
                                       3'($urandom), 3'($urandom_range(4)), 1'($urandom)));
            pick = $urandom_range(99);
            sub  = $urandom_range(9);
            if (pick < 30)
            begin
                if (sub < 7)
                    k = key_pool[$urandom_range(POOL_SIZE - 1)];
                else if (sub < 8)
                    k = codes[$urandom_range(2)];
                else
                    k = 8'($urandom);
                if (down_keys.size() < MAX_DOWN)
                    down_keys.insert(down_keys.size(), k);
                b = scrambled(CMD_PRESS, k);
            end
            else if (pick < 50)
            begin
                if (sub < 7 && down_keys.size() > 0)
                begin
                    slot = $urandom_range(down_keys.size() - 1);
                    k    = down_keys[slot];
                    down_keys.delete(slot);
                end
                else if (sub < 8)
                    k = codes[$urandom_range(2)];
                else
                    k = 8'($urandom);
                b = scrambled(CMD_RELEASE, k);
            end
            else if (pick < 60)
            begin
                if (sub < 5)
                    sel = ~(8'h01 << $urandom_range(7));
                else if (sub < 8)
                    sel = 8'($urandom);
                else
                    sel = 8'hFF;
                b = row_beat(sel);
            end
            else if (pick < 74)
                b = scrambled(CMD_READ, 8'($urandom));
            else if (pick < 91)
            begin
                k = (sub < 8) ? key_pool[$urandom_range(POOL_SIZE - 1)] : 8'($urandom);
                b = map_beat(k, 1'($urandom), 1'($urandom_range(3) == 0), 3'($urandom),
                             (sub == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4)),
                             1'($urandom));
            end
            else if (pick < 94)
                b = scrambled(CMD_CLEAR, 8'($urandom));
            else if (pick < 97)
                b = scrambled(sub < 5 ? CMD_SPARE6 : CMD_SPARE7, 8'($urandom));
            else
                b = scrambled(CMD_PRESS, key_pool[$urandom_range(POOL_SIZE - 1)]);
            send_beat(b);
        end
    endtask

    initial
    begin
        res_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0 && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                repeat (hold_off_cycles)
                begin
                    res_out.ready <= 1'b0;
                    @(negedge clk);
                end
            end
            res_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #8_000_000;
        $display("** host_key_to_scan_matrix: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        key_in.valid        = 1'b0;
        key_in.command      = CMD_READ;
        key_in.host_key     = NO_KEY;
        key_in.host_shift   = 1'b0;
        key_in.host_altgr   = 1'b0;
        key_in.target_row   = '0;
        key_in.target_col   = '0;
        key_in.target_shift = 1'b0;
        key_in.row_select   = '1;
        cfg.valid           = 1'b0;
        cfg.index           = CFG_LSHIFT;
        cfg.data            = '0;
        send_idle_pct       = 22;
        recv_idle_pct       = 45;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_codes(8'h12, 8'h59, 8'h11);

        send_beat(scrambled(CMD_READ, 8'($urandom)));
        send_beat(scrambled(CMD_PRESS, NO_KEY));
        send_beat(scrambled(CMD_RELEASE, NO_KEY));
        send_beat(map_beat(NO_KEY, 1'b0, 1'b0, 3'd1, 3'd1, 1'b0));
        send_beat(scrambled(CMD_PRESS, 8'h1C));
        send_beat(map_beat(8'h1C, 1'b0, 1'b0, 3'd7, MAX_COL, 1'b1));
        send_beat(map_beat(8'h1C, 1'b0, 1'b0, 3'd3, 3'd2, 1'b0));
        send_beat(map_beat(8'h2A, 1'b0, 1'b0, 3'd1, 3'd5, 1'b0));
        send_beat(map_beat(8'hFF, 1'b1, 1'b1, 3'd0, 3'd0, 1'b0));
        send_beat(map_beat(8'hFF, 1'b1, 1'b0, 3'd7, 3'd0, 1'b1));
        send_beat(row_beat(8'hFF));
        send_beat(row_beat(8'h00));
        send_beat(scrambled(CMD_PRESS, 8'h1C));
        send_beat(scrambled(CMD_PRESS, 8'h1C));
        send_beat(scrambled(CMD_PRESS, 8'h12));
        send_beat(scrambled(CMD_READ, 8'($urandom)));
        send_beat(scrambled(CMD_PRESS, 8'hFF));
        send_beat(row_beat(8'h7F));
        send_beat(scrambled(CMD_READ, 8'($urandom)));
        send_beat(scrambled(CMD_PRESS, 8'h11));
        send_beat(scrambled(CMD_RELEASE, 8'h11));
        send_beat(scrambled(CMD_RELEASE, 8'h59));
        send_beat(scrambled(CMD_RELEASE, 8'h33));
        send_beat(scrambled(CMD_RELEASE, 8'h1C));
        send_beat(scrambled(CMD_CLEAR, 8'($urandom)));
        send_beat(scrambled(CMD_RELEASE, 8'hFF));
        send_beat(scrambled(CMD_SPARE6, 8'($urandom)));
        send_beat(scrambled(CMD_SPARE7, 8'($urandom)));

        run_traffic(ITEMS_PER_PHASE);
        wait_idle();

        send_idle_pct = 45;
        recv_idle_pct = 22;
        load_codes(8'hFF, 8'h00, 8'hFF);
        run_traffic(ITEMS_PER_PHASE);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_codes(8'($urandom), 8'($urandom), 8'($urandom));
        // receiver stalls long while beats keep coming
        hold_off_cycles = HOLD_OFF_LEN;
        run_traffic(ITEMS_PER_PHASE);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("** host_key_to_scan_matrix: PASSED **");
        else
            $display("** host_key_to_scan_matrix: FAILED **");
        $finish;
    end

endmodule

// File: host_key_to_scan_matrix.f
rtl/hkm_pkg.sv
rtl/hkm_if.sv
rtl/hkm_map.sv
rtl/hkm_held.sv
rtl/host_key_to_scan_matrix.sv
tb/sv/hkm_checker.sv
tb/sv/tb.sv
